>>> rtl/core/ckn_pkg.sv
package ckn_pkg;

  localparam int unsigned CKN_ADDR_W = 5;
  localparam int unsigned CKN_LED_W  = 45;
  localparam int unsigned CKN_BTN_W  = 15;

  // Register map, word index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_NODE_ID     = 3'd0,
    REG_VENDOR_ID   = 3'd1,
    REG_PRODUCT     = 3'd2,
    REG_REVISION    = 3'd3,
    REG_SERIAL      = 3'd4,
    REG_BUTTON_COB  = 3'd5
  } ckn_reg_t;

  // Register reset values
  localparam logic [6:0]  RST_NODE_ID    = 7'd12;
  localparam logic [31:0] RST_VENDOR_ID  = 32'd775;
  localparam logic [31:0] RST_PRODUCT    = 32'd13131;
  localparam logic [31:0] RST_REVISION   = 32'd0;
  localparam logic [31:0] RST_SERIAL     = 32'hFFFF_FFFE;
  localparam logic [10:0] RST_BUTTON_COB = 11'd396;

  // Node state reset values
  localparam logic [7:0]  RST_LED_LEVEL  = 8'h7F;
  localparam logic [7:0]  RST_BACKLIGHT  = 8'h7F;
  localparam logic [15:0] RST_BTN_PERIOD = 16'd200;
  localparam logic [15:0] RST_HB_PERIOD  = 16'd150;

  // Function code bases
  localparam logic [10:0] ID_SDO_RX = 11'h600;
  localparam logic [10:0] ID_SDO_TX = 11'h580;
  localparam logic [10:0] ID_PDO1   = 11'h180;
  localparam logic [10:0] ID_HBEAT  = 11'h700;

  // Object dictionary indexes
  localparam logic [15:0] OD_HB_TIME   = 16'h1017;
  localparam logic [15:0] OD_IDENTITY  = 16'h1018;
  localparam logic [15:0] OD_TPDO1     = 16'h1800;
  localparam logic [15:0] OD_LED_OUT   = 16'h6200;
  localparam logic [15:0] OD_LED_LEVEL = 16'h6411;

  // SDO command codes (high nibble of request, full byte of reply)
  localparam logic [3:0] SDO_REQ_WRITE = 4'h2;
  localparam logic [3:0] SDO_REQ_READ  = 4'h4;
  localparam logic [7:0] SDO_RSP_R1    = 8'h4F;
  localparam logic [7:0] SDO_RSP_R4    = 8'h43;
  localparam logic [7:0] SDO_RSP_WACK  = 8'h60;

  localparam logic [7:0] HB_OPERATIONAL = 8'h05;

  typedef struct packed {
    logic                 action;
    logic                 on_keypad_bus;
    logic [10:0]          rx_id;
    logic [63:0]          rx_payload;
    logic [CKN_BTN_W-1:0] buttons_pressed;
  } ckn_in_t;

  typedef struct packed {
    logic                 has_frame;
    logic [10:0]          tx_id;
    logic [3:0]           tx_length;
    logic [63:0]          tx_payload;
    logic                 last;
    logic [CKN_LED_W-1:0] led_states;
    logic [7:0]           led_level;
    logic [7:0]           backlight_level;
  } ckn_out_t;

  typedef struct packed {
    logic [6:0]  node_id;
    logic [31:0] vendor_id;
    logic [31:0] product_code;
    logic [31:0] revision_number;
    logic [31:0] serial_number;
    logic [10:0] button_cob_id;
  } ckn_cfg_t;

  function automatic logic [63:0] sdo_frame(logic [7:0] cmd, logic [15:0] idx,
                                            logic [7:0] sub, logic [31:0] data);
    return {data, sub, idx, cmd};
  endfunction

endpackage

>>> rtl/core/ckn_engine.sv
module ckn_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  ckn_pkg::ckn_cfg_t cfg,
  input  ckn_pkg::ckn_in_t  item,
  input  logic              commit,
  output ckn_pkg::ckn_out_t res0,
  output ckn_pkg::ckn_out_t res1,
  output logic [1:0]        nres
);
  import ckn_pkg::*;

  logic [CKN_LED_W-1:0] led_bits_r, led_bits_nxt;
  logic [7:0]           led_lvl_r, led_lvl_nxt;
  logic [7:0]           bkl_lvl_r, bkl_lvl_nxt;
  logic [15:0]          btn_period_r, btn_period_nxt;
  logic [15:0]          hb_period_r, hb_period_nxt;
  logic [15:0]          btn_timer_r, btn_timer_nxt;
  logic [15:0]          hb_timer_r, hb_timer_nxt;

  logic [63:0] p;
  logic [3:0]  cmd;
  logic [15:0] idx;
  logic [7:0]  sub;
  logic [7:0]  b4;
  logic [15:0] w16;
  logic        for_us;
  logic [15:0] btn_inc, hb_inc;
  logic        btn_fire, hb_fire;
  logic        sdo_tx;
  logic [63:0] sdo_pay;
  logic [47:0] led_wide;
  logic [10:0] id_sdo, id_btn, id_hb;
  ckn_out_t    f_btn, f_hb, f_sdo, f_none;

  assign p      = item.rx_payload;
  assign cmd    = p[7:4];
  assign idx    = p[23:8];
  assign sub    = p[31:24];
  assign b4     = p[39:32];
  assign w16    = p[47:32];
  assign id_sdo = ID_SDO_TX + {4'd0, cfg.node_id};
  assign id_btn = ID_PDO1 + {4'd0, cfg.node_id};
  assign id_hb  = ID_HBEAT + {4'd0, cfg.node_id};
  assign for_us = !item.action && item.on_keypad_bus &&
                  (item.rx_id == ID_SDO_RX + {4'd0, cfg.node_id});

  assign btn_inc  = btn_timer_r + 16'd1;
  assign hb_inc   = hb_timer_r + 16'd1;
  assign btn_fire = item.action && (btn_inc >= btn_period_r);
  assign hb_fire  = item.action && (hb_inc >= hb_period_r);

  always_comb begin
    led_bits_nxt   = led_bits_r;
    led_lvl_nxt    = led_lvl_r;
    bkl_lvl_nxt    = bkl_lvl_r;
    btn_period_nxt = btn_period_r;
    hb_period_nxt  = hb_period_r;
    btn_timer_nxt  = btn_timer_r;
    hb_timer_nxt   = hb_timer_r;
    sdo_tx         = 1'b0;
    sdo_pay        = '0;
    led_wide       = {3'b000, led_bits_r};

    if (item.action) begin
      btn_timer_nxt = btn_fire ? 16'd0 : btn_inc;
      hb_timer_nxt  = hb_fire ? 16'd0 : hb_inc;
    end else if (for_us && cmd == SDO_REQ_WRITE) begin
      sdo_pay = sdo_frame(SDO_RSP_WACK, idx, sub, 32'd0);
      if (idx == OD_HB_TIME && sub == 8'd0) begin
        hb_period_nxt = w16;
        sdo_tx        = 1'b1;
      end else if (idx == OD_TPDO1 && sub == 8'd5) begin
        btn_period_nxt = w16;
        sdo_tx         = 1'b1;
      end else if (idx == OD_LED_OUT && sub >= 8'd1 && sub <= 8'd8) begin
        // subs 7 and 8 are acked but write no LED bits
        for (int i = 0; i < 6; i++) begin
          if (sub == 8'(i + 1)) led_wide[i*8 +: 8] = b4;
        end
        led_bits_nxt = led_wide[CKN_LED_W-1:0];
        sdo_tx       = 1'b1;
      end else if (idx == OD_LED_LEVEL && sub == 8'd1) begin
        led_lvl_nxt = b4;
        sdo_tx      = 1'b1;
      end else if (idx == OD_LED_LEVEL && sub == 8'd2) begin
        bkl_lvl_nxt = b4;
        sdo_tx      = 1'b1;
      end
    end else if (for_us && cmd == SDO_REQ_READ) begin
      if (idx == OD_IDENTITY) begin
        sdo_tx = 1'b1;
        unique case (sub)
          8'd0:    sdo_pay = sdo_frame(SDO_RSP_R1, idx, 8'd0, 32'd4);
          8'd1:    sdo_pay = sdo_frame(SDO_RSP_R4, idx, sub, cfg.vendor_id);
          8'd2:    sdo_pay = sdo_frame(SDO_RSP_R4, idx, sub, cfg.product_code);
          8'd3:    sdo_pay = sdo_frame(SDO_RSP_R4, idx, sub, cfg.revision_number);
          8'd4:    sdo_pay = sdo_frame(SDO_RSP_R4, idx, sub, cfg.serial_number);
          default: sdo_tx  = 1'b0;
        endcase
      end else if (idx == OD_TPDO1 && sub == 8'd1) begin
        sdo_tx  = 1'b1;
        sdo_pay = sdo_frame(SDO_RSP_R4, idx, sub,
                            {8'h40, 8'h00, 5'd0, cfg.button_cob_id});
      end
    end
  end

  // Frame candidates; status fields reflect state after this word
  always_comb begin
    f_none                 = '0;
    f_none.led_states      = led_bits_nxt;
    f_none.led_level       = led_lvl_nxt;
    f_none.backlight_level = bkl_lvl_nxt;

    f_btn            = f_none;
    f_btn.has_frame  = 1'b1;
    f_btn.tx_id      = id_btn;
    f_btn.tx_length  = 4'd3;
    f_btn.tx_payload = {49'd0, item.buttons_pressed};

    f_hb            = f_none;
    f_hb.has_frame  = 1'b1;
    f_hb.tx_id      = id_hb;
    f_hb.tx_length  = 4'd1;
    f_hb.tx_payload = {56'd0, HB_OPERATIONAL};

    f_sdo            = f_none;
    f_sdo.has_frame  = 1'b1;
    f_sdo.tx_id      = id_sdo;
    f_sdo.tx_length  = 4'd8;
    f_sdo.tx_payload = sdo_pay;

    f_none.last = 1'b1;
    f_btn.last  = !hb_fire;
    f_hb.last   = 1'b1;
    f_sdo.last  = 1'b1;

    res1 = f_hb;
    nres = 2'd1;
    if (btn_fire) begin
      res0 = f_btn;
      nres = hb_fire ? 2'd2 : 2'd1;
    end else if (hb_fire) begin
      res0 = f_hb;
    end else if (sdo_tx) begin
      res0 = f_sdo;
    end else begin
      res0 = f_none;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_bits_r   <= '0;
      led_lvl_r    <= RST_LED_LEVEL;
      bkl_lvl_r    <= RST_BACKLIGHT;
      btn_period_r <= RST_BTN_PERIOD;
      hb_period_r  <= RST_HB_PERIOD;
      btn_timer_r  <= '0;
      hb_timer_r   <= '0;
    end else if (commit) begin
      led_bits_r   <= led_bits_nxt;
      led_lvl_r    <= led_lvl_nxt;
      bkl_lvl_r    <= bkl_lvl_nxt;
      btn_period_r <= btn_period_nxt;
      hb_period_r  <= hb_period_nxt;
      btn_timer_r  <= btn_timer_nxt;
      hb_timer_r   <= hb_timer_nxt;
    end
  end

endmodule

>>> rtl/core/canopen_keypad_node.sv
// CANopen keypad node: expedited SDO server plus periodic button and
// heartbeat frames.
// in_*  : one word per received CAN frame (action 0) or 1 ms tick (action 1).
//         Only keypad-bus frames addressed to 0x600+node_id are served.
// out_* : one or two words per input word. last marks the final word of an
//         input; has_frame 0 means nothing to transmit (status only).
//         Every word carries the LED bits and brightnesses after the input.
// psel/penable/pwrite/paddr/pwdata/prdata/pready: APB register port,
//         registers at 4*i (node_id, identity 1..4, button COB-ID).
//         Write only while idle; pready is tied high.
// Datapath: input register, then one pass of decode logic into a two-entry
//   output queue; out_valid is set once the queue holds a word.
// Throughput: one input word per cycle while the queue has room; a tick
//   firing both timers fills both queue entries with two output words.
// A stalled receiver fills the queue; the input register then holds its
//   word and in_ready drops until enough room is free.
// Reset (rst_n, sync, active low): registers and node state to defaults,
//   queue empty, timers zero.
module canopen_keypad_node (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ckn_pkg::ckn_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ckn_pkg::ckn_out_t                  out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ckn_pkg::CKN_ADDR_W-1:0]     paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import ckn_pkg::*;

  // register file
  ckn_cfg_t cfg_r;
  ckn_reg_t reg_sel;
  logic     reg_wr;

  assign pready  = 1'b1;
  assign reg_sel = ckn_reg_t'(paddr[CKN_ADDR_W-1:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_id         <= RST_NODE_ID;
      cfg_r.vendor_id       <= RST_VENDOR_ID;
      cfg_r.product_code    <= RST_PRODUCT;
      cfg_r.revision_number <= RST_REVISION;
      cfg_r.serial_number   <= RST_SERIAL;
      cfg_r.button_cob_id   <= RST_BUTTON_COB;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_NODE_ID:    cfg_r.node_id         <= pwdata[6:0];
        REG_VENDOR_ID:  cfg_r.vendor_id       <= pwdata;
        REG_PRODUCT:    cfg_r.product_code    <= pwdata;
        REG_REVISION:   cfg_r.revision_number <= pwdata;
        REG_SERIAL:     cfg_r.serial_number   <= pwdata;
        REG_BUTTON_COB: cfg_r.button_cob_id   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NODE_ID:    prdata = {25'd0, cfg_r.node_id};
      REG_VENDOR_ID:  prdata = cfg_r.vendor_id;
      REG_PRODUCT:    prdata = cfg_r.product_code;
      REG_REVISION:   prdata = cfg_r.revision_number;
      REG_SERIAL:     prdata = cfg_r.serial_number;
      REG_BUTTON_COB: prdata = {21'd0, cfg_r.button_cob_id};
      default:        prdata = '0;
    endcase
  end

  // input register
  logic     s1_valid_r;
  ckn_in_t  s1_data_r;
  logic     advance;

  // output queue, two entries
  ckn_out_t   q_r [2];
  logic       q_rptr_r, q_wptr_r;
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic [1:0] q_free;
  logic       pop;

  ckn_out_t   res0, res1;
  logic [1:0] nres;

  ckn_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .item   (s1_data_r),
    .commit (advance),
    .res0   (res0),
    .res1   (res1),
    .nres   (nres)
  );

  assign pop       = out_valid && out_ready;
  assign q_free    = 2'd2 - q_cnt_r + {1'b0, pop};
  assign advance   = s1_valid_r && (nres <= q_free);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = (q_cnt_r != 2'd0);
  assign out_data  = q_r[q_rptr_r];
  assign q_cnt_nxt = q_cnt_r - {1'b0, pop} + (advance ? nres : 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_rptr_r <= 1'b0;
      q_wptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (pop) begin
        q_rptr_r <= !q_rptr_r;
      end
      if (advance) begin
        q_wptr_r <= q_wptr_r ^ nres[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      q_r[q_wptr_r] <= res0;
      if (nres == 2'd2) begin
        q_r[!q_wptr_r] <= res1;
      end
    end
  end

endmodule
